// ----- rtl/bcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// bcfr_pkg
// Shared constants, types and helpers for the barcode / command frame receiver.
// ----------------------------------------------------------------------------
package bcfr_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int SUM_W       = 8 + $clog2(FRAME_BYTES);
    localparam int OUT_BYTES   = 8;
    localparam int LEN_W       = 4;
    localparam int LEN_MAX     = 15;

    localparam logic [7:0] ASCII_CR   = 8'd13;
    localparam logic [7:0] ASCII_LF   = 8'd10;
    localparam logic [7:0] DIGIT_LOW  = 8'd47;
    localparam logic [7:0] DIGIT_HIGH = 8'd58;
    localparam logic [7:0] CHECK_BIAS = 8'h30;
    localparam int         CHECK_MOD  = 10;
    localparam int         RECIP_SH   = 16;
    localparam int         MOD_RECIP  = (65536 + CHECK_MOD - 1) / CHECK_MOD;

    localparam logic KIND_BARCODE = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic                     kind;
        logic [8*OUT_BYTES-1:0]   bytes;
        logic [LEN_W-1:0]         length;
    } t_result;

    function automatic logic is_term(input logic [7:0] b);
        return (b == ASCII_CR) || (b == ASCII_LF);
    endfunction

    // remainder by ten through a scaled reciprocal
    function automatic logic [3:0] mod10(input logic [SUM_W-1:0] s);
        logic [SUM_W+RECIP_SH-1:0] prod;
        logic [SUM_W-1:0]          q;
        logic [SUM_W+3:0]          qx;
        logic [SUM_W-1:0]          rem;
        prod = (SUM_W+RECIP_SH)'(s) * (SUM_W+RECIP_SH)'(MOD_RECIP);
        q    = prod[SUM_W+RECIP_SH-1:RECIP_SH];
        qx   = (SUM_W+4)'(q) * (SUM_W+4)'(CHECK_MOD);
        rem  = s - qx[SUM_W-1:0];
        return rem[3:0];
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W:0] n);
        if (int'(n) > LEN_MAX) begin
            return LEN_W'(LEN_MAX);
        end
        return LEN_W'(n);
    endfunction

endpackage

// ----- rtl/bcfr_core.sv -----
// ----------------------------------------------------------------------------
// bcfr_core
// Frame assembly state: mode, position, barcode and command buffers, and the
// result decision for each item that is advanced.
// ----------------------------------------------------------------------------
module bcfr_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_framing_error,
    output bcfr_pkg::t_result   o_result
);
    import bcfr_pkg::*;

    logic [POS_W-1:0] r_position, n_position;
    logic             r_mode, n_mode;
    logic [7:0]       r_bar [FRAME_BYTES];
    logic [7:0]       n_bar [FRAME_BYTES];
    logic [7:0]       r_cmd [FRAME_BYTES];
    logic [7:0]       n_cmd [FRAME_BYTES];

    logic             pos_zero;
    logic             pos_full;
    logic             digit;
    logic             mode;
    logic             term;
    logic [IDX_W-1:0] wr_idx;
    logic [SUM_W-1:0] sum;
    logic             check_ok;
    t_result          res;

    assign pos_zero = (r_position == '0);
    assign pos_full = (r_position == POS_W'(FRAME_BYTES));
    assign digit    = (i_rx_byte > DIGIT_LOW) && (i_rx_byte < DIGIT_HIGH);
    assign mode     = pos_zero ? ~digit : r_mode;
    assign term     = is_term(i_rx_byte);
    assign wr_idx   = r_position[IDX_W-1:0];

    always_comb begin
        sum = '0;
        for (int k = 0; k < FRAME_BYTES - 1; k++) begin
            sum = sum + SUM_W'(r_bar[k]);
        end
    end

    assign check_ok = (r_bar[FRAME_BYTES-1] == CHECK_BIAS + 8'(mod10(sum)));

    always_comb begin
        n_position = r_position;
        n_mode     = r_mode;
        n_bar      = r_bar;
        n_cmd      = r_cmd;
        res        = '0;
        if (i_framing_error) begin
            n_mode     = KIND_BARCODE;
            n_position = '0;
        end else begin
            n_mode = mode;
            if (mode == KIND_BARCODE) begin
                if (term) begin
                    n_position = '0;
                    if (pos_full && check_ok) begin
                        res.valid  = 1'b1;
                        res.kind   = KIND_BARCODE;
                        res.length = sat_len((POS_W+1)'(FRAME_BYTES));
                        for (int k = 0; k < OUT_BYTES && k < FRAME_BYTES; k++) begin
                            res.bytes[8*k +: 8] = r_bar[k];
                        end
                    end else begin
                        for (int k = 0; k < FRAME_BYTES; k++) begin
                            n_bar[k] = '0;
                        end
                    end
                end else if (!pos_full) begin
                    n_bar[wr_idx] = i_rx_byte;
                    n_position    = r_position + 1'b1;
                end else begin
                    n_position = '0;
                    for (int k = 0; k < FRAME_BYTES; k++) begin
                        n_bar[k] = '0;
                    end
                end
            end else begin
                if (!pos_full) begin
                    n_cmd[wr_idx] = i_rx_byte;
                    if (term) begin
                        n_position = '0;
                        res.valid  = 1'b1;
                        res.kind   = KIND_COMMAND;
                        res.length = sat_len({1'b0, r_position} + 1'b1);
                        for (int k = 0; k < OUT_BYTES && k < FRAME_BYTES; k++) begin
                            if (POS_W'(k) == r_position) begin
                                res.bytes[8*k +: 8] = i_rx_byte;
                            end else if (POS_W'(k) < r_position) begin
                                res.bytes[8*k +: 8] = r_cmd[k];
                            end
                        end
                    end else begin
                        n_position = r_position + 1'b1;
                    end
                end else begin
                    n_position = '0;
                    for (int k = 0; k < FRAME_BYTES; k++) begin
                        n_cmd[k] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_mode     <= KIND_BARCODE;
            for (int k = 0; k < FRAME_BYTES; k++) begin
                r_bar[k] <= '0;
                r_cmd[k] <= '0;
            end
        end else if (i_en) begin
            r_position <= n_position;
            r_mode     <= n_mode;
            r_bar      <= n_bar;
            r_cmd      <= n_cmd;
        end
    end

    always_comb begin
        o_result       = res;
        o_result.valid = res.valid & i_en;
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= POS_W'(FRAME_BYTES))
        else $error("position beyond frame size");

    a_ferr_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_framing_error) |=> (r_position == '0 && r_mode == KIND_BARCODE))
        else $error("framing error did not restart the frame");

    a_ferr_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_framing_error) |-> !o_result.valid)
        else $error("result on a framing error");

    a_emit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |=> (r_position == '0))
        else $error("position not cleared after a result");

    a_bar_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.kind == KIND_BARCODE) |->
        (o_result.length == sat_len((POS_W+1)'(FRAME_BYTES)) &&
         r_position == POS_W'(FRAME_BYTES)))
        else $error("barcode result from a partial frame");

endmodule

// ----- rtl/barcode_command_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// barcode_command_frame_receiver
// Assembles received serial bytes into checked barcode frames and commands.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready with i_rx_byte and i_framing_error, one
// received byte per item. Output channel: o_valid / i_ready with o_frame_kind,
// o_frame_bytes and o_frame_length, one item per completed barcode frame or
// command; most input items produce no output item.
// Path: an accepted byte is held in the input register until it can advance;
// the frame logic then updates state and loads the output register, so a
// result is registered there once the terminator byte advances.
// One byte per cycle unless stalled; the barcode checksum (seven-byte add and
// remainder by ten) sits in the single stage between the two registers.
// Reset (synchronous, active low) empties both registers, selects barcode
// mode, sets the position to zero and clears both frame buffers.
// When the output is stalled with a result waiting, the input register still
// takes one byte and then holds it; o_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module barcode_command_frame_receiver (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [7:0]                           i_rx_byte,
    input  logic                                 i_framing_error,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_frame_kind,
    output logic [8*bcfr_pkg::OUT_BYTES-1:0]     o_frame_bytes,
    output logic [bcfr_pkg::LEN_W-1:0]           o_frame_length
);
    import bcfr_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_ferr;
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [8*OUT_BYTES-1:0] r_out_bytes;
    logic [LEN_W-1:0]       r_out_len;
    logic                   advance;
    t_result                result;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    bcfr_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_rx_byte       (r_in_byte),
        .i_framing_error (r_in_ferr),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= result.valid;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_ferr <= i_framing_error;
        end
        if (result.valid) begin
            r_out_kind  <= result.kind;
            r_out_bytes <= result.bytes;
            r_out_len   <= result.length;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_kind   = r_out_kind;
    assign o_frame_bytes  = r_out_bytes;
    assign o_frame_length = r_out_len;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !result.valid)
        else $error("result produced while output is stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("held input item lost");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len != '0))
        else $error("output item with zero length");

endmodule
